### hdl/i2d_pkg.sv
// i2d_pkg: shared constants, types and state encoding for the integer to decimal text block
// no dependencies; used by i2d_dabble and int64_to_decimal_text
`timescale 1ns / 1ps
`default_nettype none

package i2d_pkg;

  localparam int unsigned VALUE_WIDTH  = 64;
  localparam int unsigned NumDigits    = 20;
  localparam int unsigned DigitBits    = 4;
  localparam int unsigned BcdWidth     = NumDigits * DigitBits;
  localparam int unsigned BitsPerStep  = 4;
  localparam int unsigned NumSteps     = (VALUE_WIDTH + BitsPerStep - 1) / BitsPerStep;
  localparam int unsigned ShiftWidth   = NumSteps * BitsPerStep;
  localparam int unsigned StepWidth    = (NumSteps > 1) ? $clog2(NumSteps) : 1;
  localparam int unsigned IdxWidth     = $clog2(NumDigits);
  localparam int unsigned LenWidth     = 5;
  localparam int unsigned CharWidth    = 8;

  localparam logic [CharWidth-1:0] CharZero  = 8'd48;
  localparam logic [CharWidth-1:0] CharMinus = 8'd45;

  typedef logic [BcdWidth-1:0] bcd_t;

  typedef enum logic [1:0] {
    StIdle,
    StConv,
    StLen,
    StEmit
  } state_e;

endpackage

`default_nettype wire

### hdl/i2d_dabble.sv
// i2d_dabble: shared shift-and-add-3 unit, folds BitsPerStep binary bits into the bcd accumulator
// depends on i2d_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2d_dabble (
  input  wire i2d_pkg::bcd_t                        bcd_i,
  input  wire logic [i2d_pkg::BitsPerStep-1:0]      bits_i,
  output i2d_pkg::bcd_t                             bcd_o
);

  always_comb begin
    i2d_pkg::bcd_t acc;
    logic [i2d_pkg::DigitBits-1:0] dig;
    acc = bcd_i;
    for (int s = 0; s < int'(i2d_pkg::BitsPerStep); s++) begin
      for (int d = 0; d < int'(i2d_pkg::NumDigits); d++) begin
        dig = acc[d*i2d_pkg::DigitBits +: i2d_pkg::DigitBits];
        if (dig >= 4'd5) begin
          acc[d*i2d_pkg::DigitBits +: i2d_pkg::DigitBits] = dig + 4'd3;
        end
      end
      acc = {acc[i2d_pkg::BcdWidth-2:0], bits_i[i2d_pkg::BitsPerStep-1-s]};
    end
    bcd_o = acc;
  end

endmodule

`default_nettype wire

### hdl/int64_to_decimal_text.sv
// sequence: accept in StIdle, StConv folds the magnitude through the shared dabble unit, StLen
// finds the text length, then StEmit sends one character per cycle while m_axis_tready is high
// the dabble unit takes 4 magnitude bits a cycle; input is not taken until the last character
// reset: asynchronous, active low; returns to idle and drops any number in progress
`timescale 1ns / 1ps
`default_nettype none

module int64_to_decimal_text (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // [63:0] number
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [7:0] character
  output logic             m_axis_tlast,   // last_char
  output logic [4:0]       m_axis_tuser    // [4:0] text_length
);

  i2d_pkg::state_e state_q, state_d;

  logic [i2d_pkg::ShiftWidth-1:0]  mag_q, mag_d;
  i2d_pkg::bcd_t                   bcd_q, bcd_d, bcd_step;
  logic [i2d_pkg::StepWidth-1:0]   step_q, step_d;
  logic                            sign_q, sign_d;
  logic [i2d_pkg::IdxWidth-1:0]    idx_q, idx_d;
  logic [i2d_pkg::LenWidth-1:0]    len_q, len_d;

  logic [i2d_pkg::VALUE_WIDTH-1:0] raw;
  logic                            in_neg;
  logic [i2d_pkg::VALUE_WIDTH-1:0] in_mag;
  logic [i2d_pkg::IdxWidth-1:0]    hi_digit;
  logic [i2d_pkg::DigitBits-1:0]   cur_digit;

  assign raw    = s_axis_tdata[i2d_pkg::VALUE_WIDTH-1:0];
  assign in_neg = raw[i2d_pkg::VALUE_WIDTH-1];
  assign in_mag = in_neg ? (~raw + 1'b1) : raw;

  i2d_dabble u_dabble (
    .bcd_i  (bcd_q),
    .bits_i (mag_q[i2d_pkg::ShiftWidth-1 -: i2d_pkg::BitsPerStep]),
    .bcd_o  (bcd_step)
  );

  // most significant nonzero digit, zero gives digit 0
  always_comb begin
    hi_digit = '0;
    for (int k = 0; k < int'(i2d_pkg::NumDigits); k++) begin
      if (bcd_q[k*i2d_pkg::DigitBits +: i2d_pkg::DigitBits] != '0) begin
        hi_digit = i2d_pkg::IdxWidth'(k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2d_pkg::StIdle;
      step_q  <= '0;
      sign_q  <= 1'b0;
      idx_q   <= '0;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      sign_q  <= sign_d;
      idx_q   <= idx_d;
      len_q   <= len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
    bcd_q <= bcd_d;
  end

  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    bcd_d   = bcd_q;
    step_d  = step_q;
    sign_d  = sign_q;
    idx_d   = idx_q;
    len_d   = len_q;
    case (state_q)
      i2d_pkg::StIdle: begin
        if (s_axis_tvalid) begin
          mag_d   = i2d_pkg::ShiftWidth'(in_mag);
          bcd_d   = '0;
          step_d  = '0;
          sign_d  = in_neg;
          state_d = i2d_pkg::StConv;
        end
      end
      i2d_pkg::StConv: begin
        bcd_d  = bcd_step;
        mag_d  = mag_q << i2d_pkg::BitsPerStep;
        step_d = step_q + 1'b1;
        if (step_q == i2d_pkg::StepWidth'(i2d_pkg::NumSteps - 1)) begin
          state_d = i2d_pkg::StLen;
        end
      end
      i2d_pkg::StLen: begin
        idx_d   = hi_digit;
        len_d   = i2d_pkg::LenWidth'(hi_digit) + i2d_pkg::LenWidth'(1)
                  + i2d_pkg::LenWidth'(sign_q);
        state_d = i2d_pkg::StEmit;
      end
      i2d_pkg::StEmit: begin
        if (m_axis_tready) begin
          if (sign_q) begin
            sign_d = 1'b0;
          end else if (idx_q == '0) begin
            state_d = i2d_pkg::StIdle;
          end else begin
            idx_d = idx_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = i2d_pkg::StIdle;
      end
    endcase
  end

  assign cur_digit     = bcd_q[idx_q*i2d_pkg::DigitBits +: i2d_pkg::DigitBits];
  assign s_axis_tready = (state_q == i2d_pkg::StIdle);
  assign m_axis_tvalid = (state_q == i2d_pkg::StEmit);
  assign m_axis_tdata  = sign_q ? i2d_pkg::CharMinus
                                : i2d_pkg::CharZero + i2d_pkg::CharWidth'(cur_digit);
  assign m_axis_tlast  = !sign_q && (idx_q == '0);
  assign m_axis_tuser  = len_q;

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while text is still going out");

  a_len_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser >= 5'd1 &&
                       m_axis_tuser <= i2d_pkg::LenWidth'(i2d_pkg::NumDigits)))
    else $error("text length out of range");

  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata == i2d_pkg::CharMinus) |-> !m_axis_tlast)
    else $error("minus sign marked as last character");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
    else $error("block not ready after last character");

  a_accept_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> (state_q == i2d_pkg::StConv && step_q == '0))
    else $error("conversion did not start after input transaction");

endmodule

`default_nettype wire
